/* design/gptta_pkg.sv */
package gptta_pkg;

   // Default widths of the position/velocity vectors and of the acceleration result.
   localparam int VEC_WIDTH_DEF = 32;
   localparam int ACC_WIDTH_DEF = 48;

   // Fixed field widths.
   localparam int GRAV_W   = 48;
   localparam int SCALE_W  = 32;
   localparam int MASS_W   = 16;
   localparam int THRUST_W = 16;
   localparam int DIR_W    = 2;

   // The Q16.16 position times Q16.32 mu is realigned so that over a Q16.16 cube it gives Q32.16.
   localparam int GRAV_SHIFT = 16;

   // Configuration port.
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAV_PARAMETER = 2'd0,
      CSR_THRUST_SCALE   = 2'd1
   } csr_index_type;

   // Each division term is clamped to 2^63, so 65 quotient bits settle the clamp.
   localparam int DIV_QBITS = 65;
   localparam int TERM_W    = 64;

endpackage

/* design/gravity_plus_tangential_thrust_accel.sv */
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_ready    position, velocity, mass, thrust, direction
// rsp_      out        rsp_valid / rsp_ready    acc_x, acc_y, acc_z, saturated
// csr_      in         csr_valid / csr_ready    csr_index, csr_wdata (always ready)
//
// One request enters per cycle while no result waits unread; each result passes the root
// stages (one bit each) and 66 divider stages (an input stage, then one quotient bit each).
// Reset clears the stage valid bits and both configuration registers.
// When a result waits unread, every stage holds and req_ready drops; nothing is lost.
module gravity_plus_tangential_thrust_accel #(
   parameter int VEC_WIDTH = gptta_pkg::VEC_WIDTH_DEF,
   parameter int ACC_WIDTH = gptta_pkg::ACC_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [VEC_WIDTH-1:0]       req_pos_x,
   input  logic signed [VEC_WIDTH-1:0]       req_pos_y,
   input  logic signed [VEC_WIDTH-1:0]       req_pos_z,
   input  logic signed [VEC_WIDTH-1:0]       req_vel_x,
   input  logic signed [VEC_WIDTH-1:0]       req_vel_y,
   input  logic signed [VEC_WIDTH-1:0]       req_vel_z,
   input  logic [gptta_pkg::MASS_W-1:0]      req_mass,
   input  logic [gptta_pkg::THRUST_W-1:0]    req_thrust,
   input  logic signed [gptta_pkg::DIR_W-1:0] req_direction,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ACC_WIDTH-1:0]       rsp_acc_x,
   output logic signed [ACC_WIDTH-1:0]       rsp_acc_y,
   output logic signed [ACC_WIDTH-1:0]       rsp_acc_z,
   output logic                              rsp_saturated,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gptta_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gptta_pkg::GRAV_W-1:0]      csr_wdata
);
   import gptta_pkg::*;

   localparam int V       = VEC_WIDTH;
   localparam int A       = ACC_WIDTH;
   localparam int HALF_MU = GRAV_W / 2;
   localparam int GP_W    = HALF_MU + V;
   localparam int GS_W    = GRAV_W + V;
   localparam int GN_W    = GS_W + GRAV_SHIFT;
   localparam int TP_W    = THRUST_W + SCALE_W;
   localparam int HALF_TP = TP_W / 2;
   localparam int TPV_W   = HALF_TP + V;
   localparam int TN_W    = TP_W + V;
   localparam int SQ_W    = 2 * V;
   localparam int M3_W    = 3 * V;
   localparam int MN_W    = MASS_W + V;
   localparam int DIV_LAT = DIV_QBITS + 1;
   localparam int LAT     = V + DIV_LAT + 9;

   localparam logic [TERM_W-1:0] NEG_LIM = TERM_W'(1) << (A - 1);
   localparam logic [TERM_W-1:0] POS_LIM = NEG_LIM - TERM_W'(1);

   typedef struct packed {
      logic [2:0][GN_W-1:0] gnum;
      logic [2:0][TN_W-1:0] tnum;
      logic [2:0]           pn;
      logic [2:0]           vn;
      logic [MASS_W-1:0]    mass;
      logic                 thr_nz;
      logic [DIR_W-1:0]     dir;
   } side1_type;

   typedef struct packed {
      logic [2:0]       pn;
      logic [2:0]       vn;
      logic [DIR_W-1:0] dir;
      logic             grav_on;
      logic             thr_on;
   } side2_type;

   logic en;

   // Configuration registers.
   logic [GRAV_W-1:0]  mu_ff;
   logic [SCALE_W-1:0] scale_ff;

   // Valid bits, one per stage.
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   // Stage 1: magnitudes and signs.
   logic [2:0][V-1:0] p_raw, v_raw;
   logic [2:0][V-1:0] pm1_in, vm1_in;
   logic [2:0][V-1:0] pm1_ff, vm1_ff;
   logic [2:0]        pn1_ff, vn1_ff;
   logic [MASS_W-1:0] mass1_ff;
   logic [THRUST_W-1:0] thr1_ff;
   logic [DIR_W-1:0]  dir1_ff;

   // Stage 2: squares and first partial products.
   logic [2:0][SQ_W-1:0] pq2_ff, vq2_ff;
   logic [2:0][GP_W-1:0] gpl2_ff, gph2_ff;
   logic [TP_W-1:0]      tp2_ff;
   logic [2:0][V-1:0]    vm2_ff;
   logic [2:0]           pn2_ff, vn2_ff;
   logic [MASS_W-1:0]    mass2_ff;
   logic [THRUST_W-1:0]  thr2_ff;
   logic [DIR_W-1:0]     dir2_ff;

   // Stage 3: sums of squares, gravity numerators, thrust partial products.
   logic [SQ_W-1:0]       psq3_ff, vsq3_ff;
   logic [2:0][GN_W-1:0]  gnum3_ff;
   logic [2:0][TPV_W-1:0] tpl3_ff, tph3_ff;
   logic [2:0]            pn3_ff, vn3_ff;
   logic [MASS_W-1:0]     mass3_ff;
   logic                  thr_nz3_ff;
   logic [DIR_W-1:0]      dir3_ff;

   // Stage 4: root inputs and the bundle that rides beside the roots.
   logic [SQ_W-1:0] psq4_ff, vsq4_ff;
   side1_type       s4_in, s4_ff;

   logic [V-1:0] m_root, n_root;
   side1_type    d1_ff [V];
   side1_type    d1_in [V];

   // Stages 5 to 7: cube of |r|, mass times |v|.
   logic [V-1:0]    m5_ff;
   logic [SQ_W-1:0] mm5_ff;
   logic [MN_W-1:0] mn5_ff;
   logic            thr_on5_ff;
   side1_type       s5_ff;

   logic [SQ_W-1:0] cl6_ff, ch6_ff;
   logic            m_nz6_ff;
   logic [MN_W-1:0] mn6_ff;
   logic            thr_on6_ff;
   side1_type       s6_ff;

   logic [M3_W-1:0]      m3_sum;
   logic [M3_W-1:0]      m3_7_ff;
   logic [MN_W-1:0]      mn7_ff;
   logic [2:0][GN_W-1:0] gnum7_ff;
   logic [2:0][TN_W-1:0] tnum7_ff;
   side2_type            s7_in, s7_ff;

   logic [2:0][TERM_W-1:0] gq, tq;
   side2_type              d2_ff [DIV_LAT];
   side2_type              d2_in [DIV_LAT];

   // Final two stages: signed combination, then saturation into the output register.
   logic [2:0][TERM_W-1:0] mag8_in, mag8_ff;
   logic [2:0]             rneg8_in, rneg8_ff;
   logic [2:0][A-1:0]      acc_in, acc_ff;
   logic                   sat_in, sat_ff;

   // The whole pipeline moves unless a result sits unread.
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff    <= '0;
         scale_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GRAV_PARAMETER: mu_ff    <= csr_wdata;
            CSR_THRUST_SCALE:   scale_ff <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Valid bits shift with the data.
   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Split each vector component into sign and magnitude.
   always_comb begin
      p_raw[0] = req_pos_x;
      p_raw[1] = req_pos_y;
      p_raw[2] = req_pos_z;
      v_raw[0] = req_vel_x;
      v_raw[1] = req_vel_y;
      v_raw[2] = req_vel_z;
      for (int i = 0; i < 3; i++) begin
         pm1_in[i] = p_raw[i][V-1] ? (~p_raw[i] + V'(1)) : p_raw[i];
         vm1_in[i] = v_raw[i][V-1] ? (~v_raw[i] + V'(1)) : v_raw[i];
      end
   end

   // Join the |r|^3 cube halves, which are split to keep multipliers narrow, and gate gravity.
   always_comb begin
      m3_sum = (M3_W'(ch6_ff) << V) + M3_W'(cl6_ff);
      s7_in.pn      = s6_ff.pn;
      s7_in.vn      = s6_ff.vn;
      s7_in.dir     = s6_ff.dir;
      s7_in.grav_on = m_nz6_ff && ((m3_sum >> 128) == '0);
      s7_in.thr_on  = thr_on6_ff;
   end

   always_comb begin
      s4_in.pn     = pn3_ff;
      s4_in.vn     = vn3_ff;
      s4_in.mass   = mass3_ff;
      s4_in.thr_nz = thr_nz3_ff;
      s4_in.dir    = dir3_ff;
      for (int i = 0; i < 3; i++) begin
         s4_in.gnum[i] = gnum3_ff[i];
         s4_in.tnum[i] = (TN_W'(tph3_ff[i]) << HALF_TP) + TN_W'(tpl3_ff[i]);
      end
   end

   // Front stages 1 to 4.
   always_ff @(posedge clock) begin
      if (en) begin
         pm1_ff   <= pm1_in;
         vm1_ff   <= vm1_in;
         pn1_ff   <= {p_raw[2][V-1], p_raw[1][V-1], p_raw[0][V-1]};
         vn1_ff   <= {v_raw[2][V-1], v_raw[1][V-1], v_raw[0][V-1]};
         mass1_ff <= req_mass;
         thr1_ff  <= req_thrust;
         dir1_ff  <= req_direction;

         for (int i = 0; i < 3; i++) begin
            pq2_ff[i]  <= SQ_W'(pm1_ff[i]) * SQ_W'(pm1_ff[i]);
            vq2_ff[i]  <= SQ_W'(vm1_ff[i]) * SQ_W'(vm1_ff[i]);
            gpl2_ff[i] <= GP_W'(mu_ff[HALF_MU-1:0]) * GP_W'(pm1_ff[i]);
            gph2_ff[i] <= GP_W'(mu_ff[GRAV_W-1:HALF_MU]) * GP_W'(pm1_ff[i]);
         end
         tp2_ff   <= TP_W'(thr1_ff) * TP_W'(scale_ff);
         vm2_ff   <= vm1_ff;
         pn2_ff   <= pn1_ff;
         vn2_ff   <= vn1_ff;
         mass2_ff <= mass1_ff;
         thr2_ff  <= thr1_ff;
         dir2_ff  <= dir1_ff;

         psq3_ff <= pq2_ff[0] + pq2_ff[1] + pq2_ff[2];
         vsq3_ff <= vq2_ff[0] + vq2_ff[1] + vq2_ff[2];
         for (int i = 0; i < 3; i++) begin
            gnum3_ff[i] <= {(GS_W'(gph2_ff[i]) << HALF_MU) + GS_W'(gpl2_ff[i]),
                            {GRAV_SHIFT{1'b0}}};
            tpl3_ff[i]  <= TPV_W'(tp2_ff[HALF_TP-1:0]) * TPV_W'(vm2_ff[i]);
            tph3_ff[i]  <= TPV_W'(tp2_ff[TP_W-1:HALF_TP]) * TPV_W'(vm2_ff[i]);
         end
         pn3_ff     <= pn2_ff;
         vn3_ff     <= vn2_ff;
         mass3_ff   <= mass2_ff;
         thr_nz3_ff <= thr2_ff != '0;
         dir3_ff    <= dir2_ff;

         psq4_ff <= psq3_ff;
         vsq4_ff <= vsq3_ff;
         s4_ff   <= s4_in;
      end
   end

   // Square roots of |r|^2 and |v|^2.
   gptta_isqrt #(.W(V)) u_root_r (
      .clock    (clock),
      .en       (en),
      .radicand (psq4_ff),
      .root     (m_root)
   );

   gptta_isqrt #(.W(V)) u_root_v (
      .clock    (clock),
      .en       (en),
      .radicand (vsq4_ff),
      .root     (n_root)
   );

   // Side data delay line across the root stages.
   always_comb begin
      d1_in[0] = s4_ff;
      for (int k = 1; k < V; k++) begin
         d1_in[k] = d1_ff[k-1];
      end
   end

   // Stages 5 to 7.
   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff <= d1_in;

         m5_ff      <= m_root;
         mm5_ff     <= SQ_W'(m_root) * SQ_W'(m_root);
         mn5_ff     <= MN_W'(d1_ff[V-1].mass) * MN_W'(n_root);
         thr_on5_ff <= d1_ff[V-1].thr_nz && (d1_ff[V-1].mass != '0) &&
                       (n_root != '0) && (d1_ff[V-1].dir != '0);
         s5_ff      <= d1_ff[V-1];

         cl6_ff     <= SQ_W'(mm5_ff[V-1:0]) * SQ_W'(m5_ff);
         ch6_ff     <= SQ_W'(mm5_ff[SQ_W-1:V]) * SQ_W'(m5_ff);
         m_nz6_ff   <= m5_ff != '0;
         mn6_ff     <= mn5_ff;
         thr_on6_ff <= thr_on5_ff;
         s6_ff      <= s5_ff;

         m3_7_ff  <= m3_sum;
         mn7_ff   <= mn6_ff;
         gnum7_ff <= s6_ff.gnum;
         tnum7_ff <= s6_ff.tnum;
         s7_ff    <= s7_in;
      end
   end

   // Six dividers: gravity and thrust per component.
   for (genvar i = 0; i < 3; i++) begin : g_div
      gptta_div #(.NUM_W(GN_W), .DEN_W(M3_W)) u_grav_div (
         .clock (clock),
         .en    (en),
         .num   (gnum7_ff[i]),
         .den   (m3_7_ff),
         .quo   (gq[i])
      );

      gptta_div #(.NUM_W(TN_W), .DEN_W(MN_W)) u_thr_div (
         .clock (clock),
         .en    (en),
         .num   (tnum7_ff[i]),
         .den   (mn7_ff),
         .quo   (tq[i])
      );
   end

   // Side data delay line across the divider stages.
   always_comb begin
      d2_in[0] = s7_ff;
      for (int k = 1; k < DIV_LAT; k++) begin
         d2_in[k] = d2_ff[k-1];
      end
   end

   // Add the gravity and thrust terms as sign and magnitude.
   always_comb begin
      logic [TERM_W-1:0] gm, tm, dtg;
      logic [TERM_W:0]   sum, dgt;
      logic              gneg, tneg;
      for (int i = 0; i < 3; i++) begin
         gm   = d2_ff[DIV_LAT-1].grav_on ? gq[i] : '0;
         tm   = d2_ff[DIV_LAT-1].thr_on ? tq[i] : '0;
         gneg = !d2_ff[DIV_LAT-1].pn[i];
         tneg = d2_ff[DIV_LAT-1].dir[DIR_W-1] ? !d2_ff[DIV_LAT-1].vn[i]
                                              : d2_ff[DIV_LAT-1].vn[i];
         sum  = {1'b0, gm} + {1'b0, tm};
         dgt  = {1'b0, gm} - {1'b0, tm};
         dtg  = tm - gm;
         if (gneg == tneg) begin
            mag8_in[i]  = sum[TERM_W] ? '1 : sum[TERM_W-1:0];
            rneg8_in[i] = gneg;
         end else if (!dgt[TERM_W]) begin
            mag8_in[i]  = dgt[TERM_W-1:0];
            rneg8_in[i] = gneg;
         end else begin
            mag8_in[i]  = dtg;
            rneg8_in[i] = tneg;
         end
      end
   end

   // Saturate each component to the output range.
   always_comb begin
      logic [TERM_W-1:0] lim;
      logic [2:0]        over;
      for (int i = 0; i < 3; i++) begin
         if (rneg8_ff[i]) begin
            over[i]   = mag8_ff[i] > NEG_LIM;
            lim       = over[i] ? NEG_LIM : mag8_ff[i];
            acc_in[i] = A'(TERM_W'(0) - lim);
         end else begin
            over[i]   = mag8_ff[i] > POS_LIM;
            lim       = over[i] ? POS_LIM : mag8_ff[i];
            acc_in[i] = A'(lim);
         end
      end
      sat_in = |over;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff    <= d2_in;
         mag8_ff  <= mag8_in;
         rneg8_ff <= rneg8_in;
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_acc_x     = acc_ff[0];
   assign rsp_acc_y     = acc_ff[1];
   assign rsp_acc_z     = acc_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

/* design/gptta_isqrt.sv */
module gptta_isqrt #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*W-1:0] radicand,
   output logic [W-1:0]   root
);
   import gptta_pkg::*;

   localparam int RW = W + 2;
   localparam int TW = W + 3;

   logic [RW-1:0]  rem_ff  [W];
   logic [RW-1:0]  rem_in  [W];
   logic [W-1:0]   root_ff [W];
   logic [W-1:0]   root_in [W];
   logic [2*W-1:0] x_ff    [W];
   logic [2*W-1:0] x_in    [W];

   // One root bit per stage: bring down two radicand bits and try 4*root+1.
   always_comb begin
      logic [RW-1:0]  rp;
      logic [W-1:0]   qp;
      logic [2*W-1:0] xp;
      logic [TW-1:0]  t;
      logic [TW-1:0]  trial;
      for (int k = 0; k < W; k++) begin
         if (k == 0) begin
            rp = '0;
            qp = '0;
            xp = radicand;
         end else begin
            rp = rem_ff[k-1];
            qp = root_ff[k-1];
            xp = x_ff[k-1];
         end
         t     = {rp[W:0], xp[2*W-1:2*W-2]};
         trial = TW'({qp, 2'b01});
         if (t >= trial) begin
            rem_in[k]  = RW'(t - trial);
            root_in[k] = {qp[W-2:0], 1'b1};
         end else begin
            rem_in[k]  = t[RW-1:0];
            root_in[k] = {qp[W-2:0], 1'b0};
         end
         x_in[k] = {xp[2*W-3:0], 2'b00};
      end
   end

   // Stage registers advance together with the rest of the pipeline.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         x_ff    <= x_in;
      end
   end

   assign root = root_ff[W-1];

endmodule

/* design/gptta_div.sv */
module gptta_div #(
   parameter int NUM_W = 96,
   parameter int DEN_W = 96
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [NUM_W-1:0]              num,
   input  logic [DEN_W-1:0]              den,
   output logic [gptta_pkg::TERM_W-1:0]  quo
);
   import gptta_pkg::*;

   localparam int CW = (NUM_W > DEN_W) ? NUM_W : DEN_W;
   localparam int XW = NUM_W + DIV_QBITS;
   localparam logic [TERM_W-1:0] TERM_TOP = TERM_W'(1) << (TERM_W - 1);

   logic [XW-1:0]        ext;
   logic [CW-1:0]        hi_c;
   logic [CW-1:0]        den_c;

   logic                 ovf0_ff;
   logic [DEN_W-1:0]     rem0_ff;
   logic [DIV_QBITS-1:0] low0_ff;
   logic [DEN_W-1:0]     den0_ff;

   logic [DEN_W-1:0]     rem_ff [DIV_QBITS];
   logic [DEN_W-1:0]     rem_in [DIV_QBITS];
   logic [DIV_QBITS-1:0] low_ff [DIV_QBITS];
   logic [DIV_QBITS-1:0] low_in [DIV_QBITS];
   logic [DIV_QBITS-1:0] quo_ff [DIV_QBITS];
   logic [DIV_QBITS-1:0] quo_in [DIV_QBITS];
   logic [DEN_W-1:0]     den_ff [DIV_QBITS];
   logic [DEN_W-1:0]     den_in [DIV_QBITS];
   logic                 ovf_ff [DIV_QBITS];
   logic                 ovf_in [DIV_QBITS];

   logic [DIV_QBITS-1:0] q_last;

   // The upper numerator part must stay below the divisor, else the quotient is too large.
   always_comb begin
      ext   = {{DIV_QBITS{1'b0}}, num};
      hi_c  = CW'(ext[XW-1:DIV_QBITS]);
      den_c = CW'(den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf0_ff <= hi_c >= den_c;
         rem0_ff <= hi_c[DEN_W-1:0];
         low0_ff <= ext[DIV_QBITS-1:0];
         den0_ff <= den;
      end
   end

   // Restoring division, one quotient bit per stage.
   always_comb begin
      logic [DEN_W-1:0]     rp;
      logic [DIV_QBITS-1:0] lp;
      logic [DIV_QBITS-1:0] qp;
      logic [DEN_W-1:0]     dp;
      logic                 op;
      logic [DEN_W:0]       t;
      logic                 ge;
      for (int k = 0; k < DIV_QBITS; k++) begin
         if (k == 0) begin
            rp = rem0_ff;
            lp = low0_ff;
            qp = '0;
            dp = den0_ff;
            op = ovf0_ff;
         end else begin
            rp = rem_ff[k-1];
            lp = low_ff[k-1];
            qp = quo_ff[k-1];
            dp = den_ff[k-1];
            op = ovf_ff[k-1];
         end
         t  = {rp, lp[DIV_QBITS-1]};
         ge = t >= {1'b0, dp};
         rem_in[k] = ge ? DEN_W'(t - {1'b0, dp}) : t[DEN_W-1:0];
         quo_in[k] = {qp[DIV_QBITS-2:0], ge};
         low_in[k] = {lp[DIV_QBITS-2:0], 1'b0};
         den_in[k] = dp;
         ovf_in[k] = op;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
         den_ff <= den_in;
         ovf_ff <= ovf_in;
      end
   end

   // Clamp the term magnitude to 2^63.
   always_comb begin
      q_last = quo_ff[DIV_QBITS-1];
      if (ovf_ff[DIV_QBITS-1] || q_last[DIV_QBITS-1] ||
          (q_last[TERM_W-1] && (q_last[TERM_W-2:0] != '0))) begin
         quo = TERM_TOP;
      end else begin
         quo = q_last[TERM_W-1:0];
      end
   end

endmodule

/* design/gptta_checker.sv */
module gptta_checker #(
   parameter int ACC_WIDTH = gptta_pkg::ACC_WIDTH_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ACC_WIDTH-1:0] rsp_acc_x,
   input logic [ACC_WIDTH-1:0] rsp_acc_y,
   input logic [ACC_WIDTH-1:0] rsp_acc_z,
   input logic                 rsp_saturated
);
   import gptta_pkg::*;

   localparam logic [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic [ACC_WIDTH-1:0] AMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_acc_x) &&
      $stable(rsp_acc_y) && $stable(rsp_acc_z) && $stable(rsp_saturated))
      else $error("held result changed");

   // A saturated result shows at least one component at a range limit.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
      (rsp_acc_x == AMAX || rsp_acc_x == AMIN || rsp_acc_y == AMAX ||
       rsp_acc_y == AMIN || rsp_acc_z == AMAX || rsp_acc_z == AMIN))
      else $error("saturation flag without a clipped component");

   // Requests are taken exactly when the output stage can move.
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output flow");

endmodule

bind gravity_plus_tangential_thrust_accel gptta_checker #(.ACC_WIDTH(ACC_WIDTH)) u_gptta_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_acc_x     (rsp_acc_x),
   .rsp_acc_y     (rsp_acc_y),
   .rsp_acc_z     (rsp_acc_z),
   .rsp_saturated (rsp_saturated)
);

/* bench/gravity_plus_tangential_thrust_accel_tb.sv */
module gravity_plus_tangential_thrust_accel_tb;
   import gptta_pkg::*;

   localparam int VW      = 32;
   localparam int AW      = 48;
   localparam int LATENCY = VW + 75;

   typedef struct {
      logic [AW-1:0] ax, ay, az;
      logic          sat;
   } accel_type;

   // Holds the mu and scale copies and the queue of predicted accelerations.
   class accel_scoreboard;
      logic [GRAV_W-1:0]  mu;
      logic [SCALE_W-1:0] scale;
      accel_type          pending_accel[$];
      int                 errors;

      function new();
         mu = '0;
         scale = '0;
         errors = 0;
      endfunction

      function void write_csr(csr_index_type idx, logic [GRAV_W-1:0] data);
         if (idx == CSR_GRAV_PARAMETER) begin
            mu = data;
         end else if (idx == CSR_THRUST_SCALE) begin
            scale = data[SCALE_W-1:0];
         end
      endfunction

      function logic [63:0] root_floor(logic [127:0] x);
         logic [63:0]  r;
         logic [63:0]  c;
         logic [127:0] sq;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= x) r = c;
         end
         return r;
      endfunction

      function logic [63:0] clamp63(logic [127:0] q);
         if (q > (128'd1 << 63)) return 64'h8000_0000_0000_0000;
         return q[63:0];
      endfunction

      // Predicts gravity plus thrust for one request and queues it.
      function void note_request(logic [VW-1:0] p[3], logic [VW-1:0] v[3],
                                 logic [15:0] mass, logic [15:0] thr, logic [1:0] dir);
         logic [127:0] pm[3], vm[3];
         logic [127:0] psq, vsq, m, n, m3, num, den;
         logic [63:0]  gm, tm;
         logic [64:0]  s;
         logic [63:0]  mag;
         logic [AW-1:0] res[3];
         logic         gneg, tneg, rneg, thr_on, sat;
         accel_type    e;
         psq = '0;
         vsq = '0;
         sat = 1'b0;
         for (int i = 0; i < 3; i++) begin
            pm[i] = {96'd0, p[i][VW-1] ? -p[i] : p[i]};
            vm[i] = {96'd0, v[i][VW-1] ? -v[i] : v[i]};
            psq += pm[i] * pm[i];
            vsq += vm[i] * vm[i];
         end
         m = {64'd0, root_floor(psq)};
         n = {64'd0, root_floor(vsq)};
         m3 = m * m * m;
         thr_on = thr != 0 && mass != 0 && n != 0 && dir != 0;
         for (int i = 0; i < 3; i++) begin
            gm = '0;
            tm = '0;
            gneg = !p[i][VW-1];
            tneg = dir[1] ? !v[i][VW-1] : v[i][VW-1];
            if (m != 0) begin
               num = ({80'd0, mu} * pm[i]) << GRAV_SHIFT;
               gm = clamp63(num / m3);
            end
            if (thr_on) begin
               num = {112'd0, thr} * {96'd0, scale} * vm[i];
               den = {112'd0, mass} * n;
               tm = clamp63(num / den);
            end
            if (gneg == tneg) begin
               s = {1'b0, gm} + {1'b0, tm};
               mag = s[64] ? '1 : s[63:0];
               rneg = gneg;
            end else if (gm >= tm) begin
               mag = gm - tm;
               rneg = gneg;
            end else begin
               mag = tm - gm;
               rneg = tneg;
            end
            if (rneg) begin
               if (mag > (64'd1 << (AW - 1))) begin
                  mag = 64'd1 << (AW - 1);
                  sat = 1'b1;
               end
               res[i] = -mag[AW-1:0];
            end else begin
               if (mag > (64'd1 << (AW - 1)) - 1) begin
                  mag = (64'd1 << (AW - 1)) - 1;
                  sat = 1'b1;
               end
               res[i] = mag[AW-1:0];
            end
         end
         e.ax = res[0];
         e.ay = res[1];
         e.az = res[2];
         e.sat = sat;
         pending_accel.push_back(e);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      // Compares one result with the oldest prediction.
      task check_result(accel_type got);
         accel_type e;
         if (pending_accel.size() == 0) begin
            report("result with no request outstanding");
         end else begin
            e = pending_accel.pop_front();
            if (got.ax !== e.ax) report($sformatf("acc_x %h, predicted %h", got.ax, e.ax));
            if (got.ay !== e.ay) report($sformatf("acc_y %h, predicted %h", got.ay, e.ay));
            if (got.az !== e.az) report($sformatf("acc_z %h, predicted %h", got.az, e.az));
            if (got.sat !== e.sat) report($sformatf("saturated %b, predicted %b", got.sat, e.sat));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [VW-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [VW-1:0] req_vel_x = '0, req_vel_y = '0, req_vel_z = '0;
   logic [MASS_W-1:0]    req_mass = '0;
   logic [THRUST_W-1:0]  req_thrust = '0;
   logic signed [DIR_W-1:0] req_direction = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [AW-1:0] rsp_acc_x, rsp_acc_y, rsp_acc_z;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [GRAV_W-1:0]    csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   accel_scoreboard sb = new();

   gravity_plus_tangential_thrust_accel #(.VEC_WIDTH(VW), .ACC_WIDTH(AW)) u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watches all three channels and randomizes result back-pressure.
   always @(posedge clock) begin
      logic [VW-1:0] p[3], v[3];
      accel_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            p = '{req_pos_x, req_pos_y, req_pos_z};
            v = '{req_vel_x, req_vel_y, req_vel_z};
            sb.note_request(p, v, req_mass, req_thrust, req_direction);
         end
         if (rsp_valid && rsp_ready) begin
            got.ax = rsp_acc_x;
            got.ay = rsp_acc_y;
            got.az = rsp_acc_z;
            got.sat = rsp_saturated;
            sb.check_result(got);
         end
         if (csr_valid && csr_ready) sb.write_csr(csr_index_type'(csr_index), csr_wdata);
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Writes one register, then drops csr_valid and leaves the port idle.
   task write_reg(csr_index_type idx, logic [GRAV_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drives one request and holds it until accepted, then maybe idles.
   task send_request(logic [VW-1:0] px, py, pz, vx, vy, vz,
                     logic [15:0] mass, logic [15:0] thr, logic [1:0] dir);
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_vel_z <= vz;
      req_mass <= mass;
      req_thrust <= thr;
      req_direction <= dir;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.pending_accel.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   function logic [VW-1:0] pick_vec();
      logic [VW-1:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0: return '0;
         1: return {1'b1, {(VW-1){1'b0}}};
         2: return {1'b0, {(VW-1){1'b1}}};
         3, 4: return r;
         default: return $signed(r) >>> $urandom_range(4, 24);
      endcase
   endfunction

   function logic [15:0] pick16();
      case ($urandom_range(5))
         0: return '0;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task random_requests(int count);
      for (int k = 0; k < count; k++) begin
         send_request(pick_vec(), pick_vec(), pick_vec(), pick_vec(), pick_vec(), pick_vec(),
                      pick16(), pick16(), 2'($urandom_range(3)));
      end
   endtask

   initial begin
      logic [VW-1:0] mn, mx;
      mn = {1'b1, {(VW-1){1'b0}}};
      mx = {1'b0, {(VW-1){1'b1}}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests with a moderate mu and full thrust scale.
      write_reg(CSR_GRAV_PARAMETER, 48'h0001_0000_0000);
      write_reg(CSR_THRUST_SCALE, GRAV_W'(32'hffff_ffff));
      send_request(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_request(0, 0, 0, 32'h10000, 0, 0, 100, 500, 2'sd1);
      send_request(32'h10000, 0, 0, 0, 32'h10000, 0, 100, 500, 2'sd1);
      send_request(32'h10000, 0, 0, 0, 32'h10000, 0, 100, 500, -2'sd1);
      send_request(32'h10000, 0, 0, 0, 32'h10000, 0, 100, 500, -2'sd2);
      send_request(32'h10000, 0, 0, 0, 32'h10000, 0, 100, 500, 2'sd0);
      send_request(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 500, 2'sd1);
      send_request(32'h10000, 0, 0, 0, 32'h10000, 0, 100, 0, 2'sd1);
      send_request(1, 0, 0, 0, 0, 0, 0, 0, 0);
      send_request(-1, 1, -1, 1, -1, 1, 1, 16'hffff, 2'sd1);
      send_request(mn, mn, mn, mn, mn, mn, 16'hffff, 16'hffff, -2'sd1);
      send_request(mx, mx, mx, mx, mx, mx, 16'hffff, 16'hffff, 2'sd1);
      send_request(mx, mn, 0, mn, mx, 0, 1, 16'hffff, -2'sd2);
      send_request(-32'sh30000, 32'sh40000, 0, 1, 0, 0, 1, 1, 2'sd1);
      drain();

      // Phases of idling, each with its own register setting.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         case (ph)
            0: begin write_reg(CSR_GRAV_PARAMETER, '0); write_reg(CSR_THRUST_SCALE, '0); end
            1: begin write_reg(CSR_GRAV_PARAMETER, '1); write_reg(CSR_THRUST_SCALE, '1); end
            default: begin
               write_reg(CSR_GRAV_PARAMETER,
                         GRAV_W'({$urandom, $urandom} >> $urandom_range(16, 40)));
               write_reg(CSR_THRUST_SCALE, GRAV_W'($urandom));
            end
         endcase
         random_requests(125);
         drain();
      end

      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
